/* rtl/core/etc_pkg.sv */
// Shared types, codes and helpers of the endpoint traffic counter.
// Used by every module of the block; depends on nothing.
package etc_pkg;

    localparam int MAC_ENTRIES_DEF = 32;
    localparam int IP_ENTRIES_DEF  = 32;
    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;

    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 176;
    localparam int M_TUSER_W = 3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_COUNTED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_DROPPED = 2'd2,
        ST_READ    = 2'd3
    } status_t;

    // Classified command kinds
    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_IGNORE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [15:0] frame_length;
        logic        read_table;
        logic [4:0]  read_index;
    } cmd_t;

    // Request from the sequencer to one table
    typedef struct packed {
        logic        valid;
        logic        is_read;
        logic        is_rx;
        logic [47:0] key;
        logic [15:0] len;
        logic [4:0]  idx;
    } tbl_req_t;

    // Response of one table, done pulses for one cycle
    typedef struct packed {
        logic        done;
        logic        dropped;
        logic        entry_valid;
        logic [47:0] key;
        logic [63:0] tx;
        logic [63:0] rx;
    } tbl_resp_t;

    typedef struct packed {
        status_t     status;
        logic        entry_valid;
        logic [47:0] entry_key;
        logic [63:0] tx;
        logic [63:0] rx;
    } result_t;

    // Add one packet and len bytes to a packed counter word, saturating
    function automatic logic [63:0] bump(input logic [63:0] word, input logic [15:0] len);
        logic [31:0] pk;
        logic [32:0] by;
        pk = (word[63:32] == 32'hFFFF_FFFF) ? word[63:32] : word[63:32] + 32'd1;
        by = {1'b0, word[31:0]} + {17'd0, len};
        return {pk, by[32] ? 32'hFFFF_FFFF : by[31:0]};
    endfunction

endpackage

/* rtl/core/endpoint_traffic_counter_top.sv */
// Endpoint traffic counter: per-endpoint packet and byte counts for MAC and IPv4.
// An ignored frame is answered without a table access; a read of an empty slot skips the
//   memory read; a count runs the one-slot-per-cycle key scan over the MAC and IP fill.
// The back end handles one transaction at a time; a 2-entry queue and the output register
//   let input and output stall independently.
// Reset (aresetn low, synchronous) empties both tables and the queue; no sweep.
module endpoint_traffic_counter_top
    import etc_pkg::*;
#(
    parameter int MAC_ENTRIES = MAC_ENTRIES_DEF,
    parameter int IP_ENTRIES  = IP_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ethertype, dst_mac, src_mac, dst_ip, src_ip, frame_length, read_index, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action, read_table
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // entry_key, tx packet count, tx byte count, rx packet count, rx byte count
    output logic [M_TDATA_W-1:0] m_tdata,
    // status, entry_valid
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic    cmd_valid, cmd_ready;
    cmd_t    cmd;
    result_t res;

    etc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

    etc_back #(.MAC_ENTRIES(MAC_ENTRIES), .IP_ENTRIES(IP_ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_valid(m_tvalid), .m_ready(m_tready), .res(res));

    // Pack the result transaction
    assign m_tdata = {res.rx[31:0], res.rx[63:32], res.tx[31:0], res.tx[63:32],
                      res.entry_key};
    assign m_tuser = {res.entry_valid, res.status};

endmodule

/* rtl/core/etc_front.sv */
// Front end: accepts input transactions, classifies them, queues commands.
// Depends on etc_pkg.
module etc_front
    import etc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       new_cmd;
    logic       push, pop;

    // Classify the incoming transaction
    always_comb begin
        new_cmd.dst_mac      = s_tdata[63:16];
        new_cmd.src_mac      = s_tdata[111:64];
        new_cmd.dst_ip       = s_tdata[143:112];
        new_cmd.src_ip       = s_tdata[175:144];
        new_cmd.frame_length = s_tdata[191:176];
        new_cmd.read_index   = s_tdata[196:192];
        new_cmd.read_table   = s_tuser[1];
        if (s_tuser[0]) begin
            new_cmd.kind = CMD_READ;
        end else if (s_tdata[15:0] == IPV4_ETHERTYPE) begin
            new_cmd.kind = CMD_COUNT;
        end else begin
            new_cmd.kind = CMD_IGNORE;
        end
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // Hold queue pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the classified command
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue level out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_ptr_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg)) else $error("pointer mismatch");

endmodule

/* rtl/core/etc_table.sv */
// One endpoint table: key and counter memories, fill count, linear-scan lookup.
// Depends on etc_pkg.
module etc_table
    import etc_pkg::*;
#(
    parameter int ENTRIES = MAC_ENTRIES_DEF,
    parameter int KEY_W   = 48
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  tbl_req_t  req,
    output tbl_resp_t resp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {T_IDLE, T_CMP, T_RDD} tstate_t;

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [63:0]      tx_mem  [ENTRIES];
    logic [63:0]      rx_mem  [ENTRIES];

    tstate_t          state_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    ptr_reg;
    logic [KEY_W-1:0] key_reg;
    logic [15:0]      len_reg;
    logic             rx_reg;
    tbl_resp_t        resp_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [63:0]      rd_tx_reg, rd_rx_reg;

    logic [AW-1:0]    rd_addr, wr_addr;
    logic [KEY_W-1:0] op_key;
    logic [15:0]      op_len;
    logic             op_rx;
    logic             hit, last, full, append, need_append;
    logic             done_set;
    logic             wr_key, wr_tx, wr_rx;
    logic [63:0]      new_word, wr_tx_d, wr_rx_d;

    assign resp = resp_reg;

    // Select operands, decide hit and append, form memory addresses and write data
    always_comb begin
        op_key  = (state_reg == T_IDLE) ? KEY_W'(req.key) : key_reg;
        op_len  = (state_reg == T_IDLE) ? req.len : len_reg;
        op_rx   = (state_reg == T_IDLE) ? req.is_rx : rx_reg;
        full    = (cnt_reg == CW'(ENTRIES));
        hit     = (state_reg == T_CMP) && (rd_key_reg == key_reg);
        last    = (ptr_reg + CW'(1)) == cnt_reg;
        need_append = ((state_reg == T_IDLE) && req.valid && !req.is_read
                       && (cnt_reg == '0))
                   || ((state_reg == T_CMP) && !hit && last);
        append   = need_append && !full;
        done_set = ((state_reg == T_IDLE) && req.valid
                    && (req.is_read ? (32'(req.idx) >= 32'(cnt_reg)) : (cnt_reg == '0)))
                || ((state_reg == T_CMP) && (hit || last))
                || (state_reg == T_RDD);
        new_word = bump(64'd0, op_len);
        wr_addr  = hit ? ptr_reg[AW-1:0] : AW'(cnt_reg);
        wr_key   = append;
        wr_tx    = (hit && !op_rx) || append;
        wr_rx    = (hit && op_rx) || append;
        wr_tx_d  = hit ? bump(rd_tx_reg, op_len) : (op_rx ? 64'd0 : new_word);
        wr_rx_d  = hit ? bump(rd_rx_reg, op_len) : (op_rx ? new_word : 64'd0);
        unique case (state_reg)
            T_IDLE:  rd_addr = req.is_read ? AW'(req.idx) : '0;
            T_CMP:   rd_addr = AW'(ptr_reg + CW'(1));
            default: rd_addr = '0;
        endcase
    end

    // Memory read and write ports
    always_ff @(posedge aclk) begin
        rd_key_reg <= key_mem[rd_addr];
        rd_tx_reg  <= tx_mem[rd_addr];
        rd_rx_reg  <= rx_mem[rd_addr];
        if (wr_key) key_mem[wr_addr] <= op_key;
        if (wr_tx)  tx_mem[wr_addr]  <= wr_tx_d;
        if (wr_rx)  rx_mem[wr_addr]  <= wr_rx_d;
    end

    // Sequence the lookup and hold the response
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            cnt_reg       <= '0;
            resp_reg.done <= 1'b0;
        end else begin
            resp_reg.done <= done_set;
            if (append) cnt_reg <= cnt_reg + CW'(1);
            unique case (state_reg)
                T_IDLE: begin
                    if (req.valid) begin
                        key_reg <= op_key;
                        len_reg <= req.len;
                        rx_reg  <= req.is_rx;
                        ptr_reg <= '0;
                        resp_reg.dropped     <= 1'b0;
                        resp_reg.entry_valid <= 1'b0;
                        resp_reg.key         <= '0;
                        resp_reg.tx          <= '0;
                        resp_reg.rx          <= '0;
                        if (req.is_read) begin
                            if (32'(req.idx) < 32'(cnt_reg)) begin
                                state_reg <= T_RDD;
                            end
                        end else if (cnt_reg != '0) begin
                            state_reg <= T_CMP;
                        end
                    end
                end
                T_CMP: begin
                    if (hit) begin
                        state_reg <= T_IDLE;
                    end else if (last) begin
                        resp_reg.dropped <= full;
                        state_reg        <= T_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                T_RDD: begin
                    resp_reg.entry_valid <= 1'b1;
                    resp_reg.key         <= 48'(rd_key_reg);
                    resp_reg.tx          <= rd_tx_reg;
                    resp_reg.rx          <= rd_rx_reg;
                    state_reg            <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= ENTRIES) else $error("fill count beyond table size");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        resp_reg.done |=> !resp_reg.done) else $error("done held over two cycles");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != $past(cnt_reg) |-> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("fill count jumped");

endmodule

/* rtl/core/etc_back.sv */
// Back end: runs count commands against both tables and reads against one, registers results.
// Depends on etc_pkg and etc_table.
module etc_back
    import etc_pkg::*;
#(
    parameter int MAC_ENTRIES = MAC_ENTRIES_DEF,
    parameter int IP_ENTRIES  = IP_ENTRIES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res
);

    typedef enum logic {B_IDLE, B_WAIT} bstate_t;

    bstate_t   state_reg;
    cmd_t      cmd_reg;
    logic [1:0] step_reg;
    logic      drop_reg;
    logic      sel_ip_reg;
    tbl_req_t  mac_req_reg, ip_req_reg;
    tbl_req_t  mac_req_next, ip_req_next;
    logic      m_valid_reg;
    result_t   res_reg;
    tbl_resp_t mac_resp, ip_resp;
    tbl_resp_t cur_resp;
    logic      out_free;
    logic      drop_n;
    logic      start, step_done, emit;
    tbl_req_t  next_req;
    logic [1:0] next_step;

    // Build the table request for one step of a count command
    function automatic tbl_req_t step_req(input cmd_t c, input logic [1:0] s);
        tbl_req_t r;
        r.valid   = 1'b1;
        r.is_read = 1'b0;
        r.is_rx   = !s[0];
        r.len     = c.frame_length;
        r.idx     = c.read_index;
        unique case (s)
            2'd0:    r.key = c.dst_mac;
            2'd1:    r.key = c.src_mac;
            2'd2:    r.key = {16'd0, c.dst_ip};
            default: r.key = {16'd0, c.src_ip};
        endcase
        return r;
    endfunction

    // Build the table request for a read command
    function automatic tbl_req_t read_req(input cmd_t c);
        tbl_req_t r;
        r         = step_req(c, 2'd0);
        r.is_read = 1'b1;
        return r;
    endfunction

    etc_table #(.ENTRIES(MAC_ENTRIES), .KEY_W(48)) u_mac (
        .aclk(aclk), .aresetn(aresetn), .req(mac_req_reg), .resp(mac_resp));
    etc_table #(.ENTRIES(IP_ENTRIES), .KEY_W(32)) u_ip (
        .aclk(aclk), .aresetn(aresetn), .req(ip_req_reg), .resp(ip_resp));

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == B_IDLE) && out_free;
    assign m_valid   = m_valid_reg;
    assign res       = res_reg;
    assign cur_resp  = sel_ip_reg ? ip_resp : mac_resp;
    assign drop_n    = drop_reg || cur_resp.dropped;
    assign next_step = step_reg + 2'd1;
    assign next_req  = step_req(cmd_reg, next_step);
    assign start     = (state_reg == B_IDLE) && cmd_valid && cmd_ready;
    assign step_done = (state_reg == B_WAIT) && cur_resp.done;
    assign emit      = (start && (cmd.kind != CMD_READ) && (cmd.kind != CMD_COUNT))
                    || (step_done && ((cmd_reg.kind == CMD_READ) || (step_reg == 2'd3)));

    // Issue at most one table request per cycle
    always_comb begin
        mac_req_next       = mac_req_reg;
        ip_req_next        = ip_req_reg;
        mac_req_next.valid = 1'b0;
        ip_req_next.valid  = 1'b0;
        if (start && (cmd.kind == CMD_READ)) begin
            if (cmd.read_table) ip_req_next = read_req(cmd);
            else                mac_req_next = read_req(cmd);
        end else if (start && (cmd.kind == CMD_COUNT)) begin
            mac_req_next = step_req(cmd, 2'd0);
        end else if (step_done && !emit) begin
            if (next_step[1]) ip_req_next = next_req;
            else              mac_req_next = next_req;
        end
    end

    // Sequence table operations and hold the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            mac_req_reg <= '0;
            ip_req_reg  <= '0;
        end else begin
            mac_req_reg <= mac_req_next;
            ip_req_reg  <= ip_req_next;
            m_valid_reg <= emit || (m_valid_reg && !m_ready);
            unique case (state_reg)
                B_IDLE: begin
                    if (start) begin
                        cmd_reg  <= cmd;
                        step_reg <= 2'd0;
                        drop_reg <= 1'b0;
                        unique case (cmd.kind)
                            CMD_READ: begin
                                sel_ip_reg <= cmd.read_table;
                                state_reg  <= B_WAIT;
                            end
                            CMD_COUNT: begin
                                sel_ip_reg <= 1'b0;
                                state_reg  <= B_WAIT;
                            end
                            default: begin
                                res_reg <= '{status: ST_IGNORED, entry_valid: 1'b0,
                                             entry_key: 48'd0, tx: 64'd0, rx: 64'd0};
                            end
                        endcase
                    end
                end
                B_WAIT: begin
                    if (cur_resp.done) begin
                        if (cmd_reg.kind == CMD_READ) begin
                            res_reg.status      <= ST_READ;
                            res_reg.entry_valid <= cur_resp.entry_valid;
                            res_reg.entry_key   <= cur_resp.key;
                            res_reg.tx          <= cur_resp.tx;
                            res_reg.rx          <= cur_resp.rx;
                            state_reg           <= B_IDLE;
                        end else if (step_reg == 2'd3) begin
                            res_reg <= '{status: drop_n ? ST_DROPPED : ST_COUNTED,
                                         entry_valid: 1'b0, entry_key: 48'd0,
                                         tx: 64'd0, rx: 64'd0};
                            state_reg <= B_IDLE;
                        end else begin
                            drop_reg   <= drop_n;
                            step_reg   <= next_step;
                            sel_ip_reg <= next_step[1];
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mac_req_reg.valid && ip_req_reg.valid)) else $error("two tables started");
    a_req_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (mac_req_reg.valid || ip_req_reg.valid) |-> state_reg == B_WAIT)
        else $error("request outside wait");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(res_reg)) else $error("result overwritten");

endmodule

/* bench/tb.sv */
// Self-checking bench for endpoint_traffic_counter_top: random and directed traffic.
// Depends on etc_pkg and the top module of the block.
module tb
    import etc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAB = 32;

    typedef struct {
        logic        action;
        logic [15:0] eth_type;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [15:0] frame_length;
        logic        read_table;
        logic [4:0]  read_index;
    } frame_t;

    typedef struct {
        status_t     status;
        logic        entry_valid;
        logic [47:0] entry_key;
        logic [31:0] tx_pk, tx_by, rx_pk, rx_by;
    } reply_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    endpoint_traffic_counter_top DUT (.*);

    // Shadow tables, index 0 MAC, 1 IPv4
    logic        slot_used [2][NTAB];
    logic [47:0] slot_key  [2][NTAB];
    logic [63:0] slot_tx   [2][NTAB];
    logic [63:0] slot_rx   [2][NTAB];

    frame_t pending_frames[$];
    reply_t expected_replies[$];
    int     errors = 0;
    bit     stim_done = 0;
    bit     hold_off = 0;

    // Saturating add of one packet and len bytes
    function automatic logic [63:0] add_traffic(logic [63:0] w, logic [15:0] len);
        logic [31:0] pk;
        logic [32:0] by;
        pk = (w[63:32] == '1) ? w[63:32] : w[63:32] + 32'd1;
        by = {1'b0, w[31:0]} + {17'd0, len};
        return {pk, by[32] ? 32'hFFFF_FFFF : by[31:0]};
    endfunction

    // Update one table for one key; returns 0 when a new key finds no slot
    function automatic bit account(int t, logic [47:0] key, bit is_rx, logic [15:0] len);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < NTAB; i++) begin
            if (slot_used[t][i] && slot_key[t][i] == key) begin
                if (is_rx) slot_rx[t][i] = add_traffic(slot_rx[t][i], len);
                else slot_tx[t][i] = add_traffic(slot_tx[t][i], len);
                return 1;
            end
            if (!slot_used[t][i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) return 0;
        slot_used[t][free_slot] = 1;
        slot_key[t][free_slot] = key;
        slot_tx[t][free_slot] = '0;
        slot_rx[t][free_slot] = '0;
        if (is_rx) slot_rx[t][free_slot] = add_traffic('0, len);
        else slot_tx[t][free_slot] = add_traffic('0, len);
        return 1;
    endfunction

    function automatic reply_t predict_reply(frame_t f);
        reply_t r;
        bit ok;
        int t;
        r = '{ST_COUNTED, 1'b0, '0, '0, '0, '0, '0};
        if (f.action) begin
            r.status = ST_READ;
            t = f.read_table;
            if (slot_used[t][f.read_index]) begin
                r.entry_valid = 1;
                r.entry_key = t ? {16'd0, slot_key[t][f.read_index][31:0]}
                                : slot_key[t][f.read_index];
                {r.tx_pk, r.tx_by} = slot_tx[t][f.read_index];
                {r.rx_pk, r.rx_by} = slot_rx[t][f.read_index];
            end
        end else if (f.eth_type != IPV4_ETHERTYPE) begin
            r.status = ST_IGNORED;
        end else begin
            ok = 1;
            ok &= account(0, f.dst_mac, 1, f.frame_length);
            ok &= account(0, f.src_mac, 0, f.frame_length);
            ok &= account(1, {16'd0, f.dst_ip}, 1, f.frame_length);
            ok &= account(1, {16'd0, f.src_ip}, 0, f.frame_length);
            r.status = ok ? ST_COUNTED : ST_DROPPED;
        end
        return r;
    endfunction

    function automatic frame_t count_frame(logic [47:0] dm, logic [47:0] sm,
                                           logic [31:0] di, logic [31:0] si,
                                           logic [15:0] len);
        frame_t f;
        f.action = 0; f.eth_type = IPV4_ETHERTYPE;
        f.dst_mac = dm; f.src_mac = sm; f.dst_ip = di; f.src_ip = si;
        f.frame_length = len;
        f.read_table = 1'($urandom); f.read_index = 5'($urandom);
        return f;
    endfunction

    function automatic frame_t read_frame(logic tbl, logic [4:0] idx);
        frame_t f;
        f = count_frame(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        $urandom, $urandom, 16'($urandom));
        f.action = 1; f.eth_type = 16'($urandom);
        f.read_table = tbl; f.read_index = idx;
        return f;
    endfunction

    // Clock and reset
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;
    end

    // Driver: bursts with random gaps, fed from pending_frames
    logic s_tready_q = 0;
    int burst_left = 0, gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_tready_q)) begin
            if (pending_frames.size() == 0) begin
                s_tvalid <= 0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 0;
            end else begin
                frame_t f;
                f = pending_frames.pop_front();
                s_tdata <= S_TDATA_W'({f.read_index, f.frame_length, f.src_ip, f.dst_ip,
                                       f.src_mac, f.dst_mac, f.eth_type});
                s_tuser <= {f.read_table, f.action};
                s_tvalid <= 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Record acceptance at the rising edge; predict there
    always @(posedge aclk) begin
        s_tready_q <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            frame_t f;
            f.eth_type = s_tdata[15:0];
            f.dst_mac = s_tdata[63:16];
            f.src_mac = s_tdata[111:64];
            f.dst_ip = s_tdata[143:112];
            f.src_ip = s_tdata[175:144];
            f.frame_length = s_tdata[191:176];
            f.read_index = s_tdata[196:192];
            f.action = s_tuser[0];
            f.read_table = s_tuser[1];
            expected_replies.push_back(predict_reply(f));
        end
    end

    // Receiver stall pattern plus one long hold-off
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (hold_off) m_tready <= 0;
        else if (stall_phase[8]) m_tready <= 1;
        else m_tready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
    end

    initial begin
        @(posedge aresetn);
        repeat (200) @(posedge aclk);
        hold_off = 1;
        repeat (400) @(posedge aclk);
        hold_off = 0;
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            reply_t got, want;
            got.entry_key = m_tdata[47:0];
            got.tx_pk = m_tdata[79:48];
            got.tx_by = m_tdata[111:80];
            got.rx_pk = m_tdata[143:112];
            got.rx_by = m_tdata[175:144];
            got.status = status_t'(m_tuser[1:0]);
            got.entry_valid = m_tuser[2];
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, got.status);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.entry_valid !== want.entry_valid) begin
                    $display("%0t: entry_valid exp %0b got %0b", $time,
                             want.entry_valid, got.entry_valid);
                    errors++;
                end
                if (got.entry_key !== want.entry_key) begin
                    $display("%0t: entry_key exp %h got %h", $time,
                             want.entry_key, got.entry_key);
                    errors++;
                end
                if ({got.tx_pk, got.tx_by} !== {want.tx_pk, want.tx_by}) begin
                    $display("%0t: tx exp %h/%h got %h/%h", $time, want.tx_pk,
                             want.tx_by, got.tx_pk, got.tx_by);
                    errors++;
                end
                if ({got.rx_pk, got.rx_by} !== {want.rx_pk, want.rx_by}) begin
                    $display("%0t: rx exp %h/%h got %h/%h", $time, want.rx_pk,
                             want.rx_by, got.rx_pk, got.rx_by);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    logic [47:0] mac_pool[48];
    logic [31:0] ip_pool[48];
    initial begin
        frame_t f;
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < NTAB; i++) slot_used[t][i] = 0;
        for (int i = 0; i < 48; i++) begin
            mac_pool[i] = 48'({$urandom, $urandom});
            ip_pool[i] = $urandom;
        end
        // Directed: empty reads, ignored frame, extremes, same endpoint
        pending_frames.push_back(read_frame(1'b0, 5'd0));
        pending_frames.push_back(read_frame(1'b1, 5'd31));
        f = count_frame('1, '1, '1, '1, '1); f.eth_type = 16'h86DD;
        pending_frames.push_back(f);
        f = count_frame('1, '1, '1, '1, '1); f.eth_type = 16'hFFFF;
        pending_frames.push_back(f);
        pending_frames.push_back(count_frame('0, '1, '0, '1, '0));
        pending_frames.push_back(count_frame('1, '1, '1, '1, 16'hFFFF));
        pending_frames.push_back(count_frame(48'h5, 48'h5, 32'h7, 32'h7, 16'd64));
        pending_frames.push_back(read_frame(1'b0, 5'd0));
        pending_frames.push_back(read_frame(1'b0, 5'd1));
        pending_frames.push_back(read_frame(1'b1, 5'd1));
        pending_frames.push_back(read_frame(1'b1, 5'd2));
        // Push more traffic through the all-ones MAC entry, then read it back
        for (int i = 0; i < 6; i++)
            pending_frames.push_back(count_frame('1, '1, '1, '1, 16'hFFFF));
        pending_frames.push_back(read_frame(1'b0, 5'd1));
        // Random: traffic among a pool larger than the tables, then reads
        for (int n = 0; n < 1200; n++) begin
            int k;
            k = $urandom_range(0, 9);
            if (k < 6) begin
                int lim;
                lim = (n < 400) ? 20 : 47;
                f = count_frame(mac_pool[$urandom_range(0, lim)],
                                mac_pool[$urandom_range(0, lim)],
                                ip_pool[$urandom_range(0, lim)],
                                ip_pool[$urandom_range(0, lim)], 16'($urandom));
            end else if (k < 8) begin
                f = read_frame(1'($urandom), 5'($urandom));
            end else if (k == 8) begin
                f = count_frame(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                $urandom, $urandom, 16'($urandom));
                if ($urandom_range(0, 1)) f.eth_type = 16'($urandom);
            end else begin
                f = count_frame(mac_pool[0], mac_pool[0], ip_pool[0], ip_pool[0],
                                16'($urandom));
            end
            pending_frames.push_back(f);
        end
        for (int i = 0; i < 32; i++) begin
            pending_frames.push_back(read_frame(1'b0, 5'(i)));
            pending_frames.push_back(read_frame(1'b1, 5'(i)));
        end
        wait (pending_frames.size() == 0 && !s_tvalid);
        wait (expected_replies.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Overall time limit
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
